// ===== sv/vcr_pkg.sv =====
`default_nettype none
package vcr_pkg;

	localparam int POS_W   = 48;
	localparam int HALF_W  = 47;
	localparam int IDX_W   = 16;
	localparam int CELL_W  = 20;
	localparam int DIV_W   = CELL_W + IDX_W;
	localparam int CNTD_W  = DIV_W + IDX_W;
	localparam int BOUND_W = POS_W;
	localparam int LANES   = 4;

	typedef struct packed {
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
		logic [HALF_W-1:0]       half_width;
		logic [HALF_W-1:0]       half_height;
		logic [IDX_W-1:0]        margin_chunks;
	} query_t;

	typedef struct packed {
		logic             intersects;
		logic [IDX_W-1:0] min_chunk_x;
		logic [IDX_W-1:0] min_chunk_y;
		logic [IDX_W-1:0] max_chunk_x;
		logic [IDX_W-1:0] max_chunk_y;
	} result_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] margin;
	} side_t;

	typedef logic [LANES-1:0][BOUND_W-1:0] bound_vec_t;
	typedef logic [LANES-1:0][IDX_W-1:0]   quo_vec_t;

endpackage
`default_nettype wire

// ===== sv/viewport_chunk_range_core.sv =====
//  channel  | role   | handshake                          | payload
//  query    | in     | query_valid / query_ready          | vcr_pkg::query_t
//  result   | out    | result_valid / result_ready        | vcr_pkg::result_t
//  config   | in/out | psel penable pwrite paddr pwdata   | 32-bit registers at 4*i
//
//  One query enters per cycle while no stall on result backs up to the front.
//  The divider resolves one quotient bit per stage, 16 stages, behind a
//  range-check stage, three front stages and the result register.
//  Reset clears the valid bits and restores the register defaults.
//  A stall on result backs up only through full stages; bubbles still fill.
`default_nettype none
module viewport_chunk_range_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            query_valid,
	output logic            query_ready,
	input  vcr_pkg::query_t query,
	output logic            result_valid,
	input  logic            result_ready,
	output vcr_pkg::result_t result,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import vcr_pkg::*;

	typedef enum logic [2:0] {
		REG_CELL_SIZE  = 3'd0,
		REG_MAP_W      = 3'd1,
		REG_MAP_H      = 3'd2,
		REG_CHUNK_SIZE = 3'd3,
		REG_COUNT_X    = 3'd4,
		REG_COUNT_Y    = 3'd5
	} cfg_reg_t;

	logic [CELL_W-1:0] cell_size_q;
	logic [IDX_W-1:0]  map_w_q, map_h_q, chunk_size_q, count_x_q, count_y_q;
	logic [DIV_W-1:0]  dnz_q, map_max_x_q, map_max_y_q;
	logic              dzero_q;
	logic [CNTD_W-1:0] cntd_x_q, cntd_y_q;

	logic [CELL_W-1:0] cs_nz;
	logic [IDX_W-1:0]  ch_nz, cx_nz, cy_nz;
	logic              wr_en;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cs_nz   = (cell_size_q == '0) ? CELL_W'(1) : cell_size_q;
	assign ch_nz   = (chunk_size_q == '0) ? IDX_W'(1) : chunk_size_q;
	assign cx_nz   = (count_x_q == '0) ? IDX_W'(1) : count_x_q;
	assign cy_nz   = (count_y_q == '0) ? IDX_W'(1) : count_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= CELL_W'(65536);
			map_w_q      <= IDX_W'(256);
			map_h_q      <= IDX_W'(256);
			chunk_size_q <= IDX_W'(16);
			count_x_q    <= IDX_W'(16);
			count_y_q    <= IDX_W'(16);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CELL_SIZE:  cell_size_q  <= pwdata[CELL_W-1:0];
				REG_MAP_W:      map_w_q      <= pwdata[IDX_W-1:0];
				REG_MAP_H:      map_h_q      <= pwdata[IDX_W-1:0];
				REG_CHUNK_SIZE: chunk_size_q <= pwdata[IDX_W-1:0];
				REG_COUNT_X:    count_x_q    <= pwdata[IDX_W-1:0];
				REG_COUNT_Y:    count_y_q    <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CELL_SIZE:  prdata = {{(32-CELL_W){1'b0}}, cell_size_q};
			REG_MAP_W:      prdata = {{(32-IDX_W){1'b0}}, map_w_q};
			REG_MAP_H:      prdata = {{(32-IDX_W){1'b0}}, map_h_q};
			REG_CHUNK_SIZE: prdata = {{(32-IDX_W){1'b0}}, chunk_size_q};
			REG_COUNT_X:    prdata = {{(32-IDX_W){1'b0}}, count_x_q};
			REG_COUNT_Y:    prdata = {{(32-IDX_W){1'b0}}, count_y_q};
			default:        prdata = '0;
		endcase
	end

	// derived geometry, refreshed every cycle from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dnz_q       <= DIV_W'(1 << 20);
			dzero_q     <= 1'b0;
			map_max_x_q <= DIV_W'(1 << 24);
			map_max_y_q <= DIV_W'(1 << 24);
			cntd_x_q    <= CNTD_W'(1 << 24);
			cntd_y_q    <= CNTD_W'(1 << 24);
		end else begin
			dnz_q       <= {{IDX_W{1'b0}}, cs_nz} * {{CELL_W{1'b0}}, ch_nz};
			dzero_q     <= (cell_size_q == '0) || (chunk_size_q == '0);
			map_max_x_q <= {{IDX_W{1'b0}}, cell_size_q} * {{CELL_W{1'b0}}, map_w_q};
			map_max_y_q <= {{IDX_W{1'b0}}, cell_size_q} * {{CELL_W{1'b0}}, map_h_q};
			cntd_x_q    <= {{DIV_W{1'b0}}, cx_nz} * {{IDX_W{1'b0}}, dnz_q};
			cntd_y_q    <= {{DIV_W{1'b0}}, cy_nz} * {{IDX_W{1'b0}}, dnz_q};
		end
	end

	function automatic logic [BOUND_W-1:0] pos_part(input logic signed [POS_W:0] v);
		pos_part = (v > 0) ? v[BOUND_W-1:0] : '0;
	endfunction

	function automatic logic [BOUND_W-1:0] top_bound(input logic signed [POS_W:0] hi,
			input logic [DIV_W-1:0] mmax);
		logic signed [POS_W:0] m;
		logic signed [POS_W:0] t;
		m = $signed({{(POS_W+1-DIV_W){1'b0}}, mmax});
		t = (hi < m) ? hi : m;
		if (t > 0) begin
			t = t - 1;
		end
		top_bound = pos_part(t);
	endfunction

	function automatic logic misses(input logic signed [POS_W:0] lo,
			input logic signed [POS_W:0] hi, input logic [CNTD_W-1:0] mw,
			input logic [DIV_W-1:0] mmax);
		logic signed [CNTD_W+1:0] lo_e, hi_e, mw_e, mx_e;
		lo_e = {{(CNTD_W+1-POS_W){lo[POS_W]}}, lo};
		hi_e = {{(CNTD_W+1-POS_W){hi[POS_W]}}, hi};
		mw_e = $signed({2'b00, mw});
		mx_e = $signed({{(CNTD_W+2-DIV_W){1'b0}}, mmax});
		misses = (hi_e + mw_e <= 0) || (lo_e - mw_e >= mx_e);
	endfunction

	// stage ready chain
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out, div_in_ready;
	logic v_s1, v_s2, v_s3;

	assign rdy_out     = !result_valid || result_ready;
	assign rdy_s3      = !v_s3 || div_in_ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign query_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= query_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	query_t                 q_s1;
	logic signed [POS_W:0]  min_x_s2, max_x_s2, min_y_s2, max_y_s2;
	logic [CNTD_W-1:0]      mw_s2;
	logic [IDX_W-1:0]       margin_s2;
	bound_vec_t             bound_s3;
	side_t                  side_s3;

	logic signed [POS_W:0]  cx_e, cy_e, hw_e, hh_e;
	logic [CNTD_W-1:0]      mw_prod;

	assign cx_e    = {q_s1.center_x[POS_W-1], q_s1.center_x};
	assign cy_e    = {q_s1.center_y[POS_W-1], q_s1.center_y};
	assign hw_e    = $signed({2'b00, q_s1.half_width});
	assign hh_e    = $signed({2'b00, q_s1.half_height});
	assign mw_prod = {{DIV_W{1'b0}}, q_s1.margin_chunks} * {{IDX_W{1'b0}}, dnz_q};

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			q_s1 <= query;
		end
		if (rdy_s2) begin
			min_x_s2  <= cx_e - hw_e;
			max_x_s2  <= cx_e + hw_e;
			min_y_s2  <= cy_e - hh_e;
			max_y_s2  <= cy_e + hh_e;
			mw_s2     <= dzero_q ? '0 : mw_prod;
			margin_s2 <= q_s1.margin_chunks;
		end
		if (rdy_s3) begin
			bound_s3[0]    <= pos_part(min_x_s2);
			bound_s3[1]    <= top_bound(max_x_s2, map_max_x_q);
			bound_s3[2]    <= pos_part(min_y_s2);
			bound_s3[3]    <= top_bound(max_y_s2, map_max_y_q);
			side_s3.hit    <= !(misses(min_x_s2, max_x_s2, mw_s2, map_max_x_q) ||
				misses(min_y_s2, max_y_s2, mw_s2, map_max_y_q));
			side_s3.margin <= margin_s2;
		end
	end

	logic             div_valid;
	quo_vec_t         div_quo;
	logic [LANES-1:0] div_over;
	side_t            div_side;

	vcr_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.bound_in  (bound_s3),
		.side_in   (side_s3),
		.dnz       (dnz_q),
		.cntd_x    (cntd_x_q),
		.cntd_y    (cntd_y_q),
		.out_valid (div_valid),
		.out_ready (rdy_out),
		.quo_out   (div_quo),
		.over_out  (div_over),
		.side_out  (div_side)
	);

	function automatic logic [IDX_W-1:0] lower_idx(input logic [IDX_W-1:0] q,
			input logic over, input logic [IDX_W-1:0] cm1, input logic [IDX_W-1:0] m);
		logic [IDX_W-1:0] a;
		a = over ? cm1 : q;
		lower_idx = (a > m) ? a - m : '0;
	endfunction

	function automatic logic [IDX_W-1:0] upper_idx(input logic [IDX_W-1:0] q,
			input logic over, input logic [IDX_W-1:0] cm1, input logic [IDX_W-1:0] m);
		logic [IDX_W-1:0] b;
		logic [IDX_W:0]   s;
		b = over ? cm1 : q;
		s = {1'b0, b} + {1'b0, m};
		upper_idx = (s > {1'b0, cm1}) ? cm1 : s[IDX_W-1:0];
	endfunction

	logic [IDX_W-1:0] cm1_x, cm1_y;
	result_t          res_d;

	assign cm1_x = cx_nz - IDX_W'(1);
	assign cm1_y = cy_nz - IDX_W'(1);

	always_comb begin
		res_d = '0;
		if (div_side.hit) begin
			res_d.intersects  = 1'b1;
			res_d.min_chunk_x = lower_idx(div_quo[0], div_over[0], cm1_x, div_side.margin);
			res_d.max_chunk_x = upper_idx(div_quo[1], div_over[1], cm1_x, div_side.margin);
			res_d.min_chunk_y = lower_idx(div_quo[2], div_over[2], cm1_y, div_side.margin);
			res_d.max_chunk_y = upper_idx(div_quo[3], div_over[3], cm1_y, div_side.margin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (rdy_out) begin
			result_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			result <= res_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/vcr_div_pipe.sv =====
`default_nettype none
module vcr_div_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  vcr_pkg::bound_vec_t        bound_in,
	input  vcr_pkg::side_t             side_in,
	input  logic [vcr_pkg::DIV_W-1:0]  dnz,
	input  logic [vcr_pkg::CNTD_W-1:0] cntd_x,
	input  logic [vcr_pkg::CNTD_W-1:0] cntd_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output vcr_pkg::quo_vec_t          quo_out,
	output logic [vcr_pkg::LANES-1:0]  over_out,
	output vcr_pkg::side_t             side_out
);
	import vcr_pkg::*;

	localparam int NST = IDX_W + 1;
	localparam int TW  = CNTD_W;

	logic [NST-1:0]   v_s;
	logic [NST-1:0]   rdy;
	bound_vec_t       rem_s  [NST];
	quo_vec_t         quo_s  [NST];
	logic [LANES-1:0] over_s [NST];
	side_t            side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		if (k == NST - 1) begin : g_last
			assign rdy[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					for (int l = 0; l < LANES; l++) begin
						rem_s[k][l]  <= bound_in[l];
						quo_s[k][l]  <= '0;
						over_s[k][l] <= {{(TW-BOUND_W){1'b0}}, bound_in[l]} >=
							((l < 2) ? cntd_x : cntd_y);
					end
					side_s[k] <= side_in;
				end
			end
		end else begin : g_step
			localparam int B = IDX_W - k;
			logic [TW-1:0]    sub;
			logic [TW:0]      diff [LANES];
			logic [IDX_W-1:0] qn   [LANES];

			assign sub = {{(TW-DIV_W){1'b0}}, dnz} << B;

			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					diff[l]  = {{(TW+1-BOUND_W){1'b0}}, rem_s[k-1][l]} - {1'b0, sub};
					qn[l]    = quo_s[k-1][l];
					qn[l][B] = !diff[l][TW];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					for (int l = 0; l < LANES; l++) begin
						quo_s[k][l] <= qn[l];
						if (!diff[l][TW]) begin
							rem_s[k][l] <= diff[l][BOUND_W-1:0];
						end else begin
							rem_s[k][l] <= rem_s[k-1][l];
						end
					end
					over_s[k] <= over_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[NST-1];
	assign quo_out   = quo_s[NST-1];
	assign over_out  = over_s[NST-1];
	assign side_out  = side_s[NST-1];

endmodule
`default_nettype wire

// ===== dv/tb_viewport_chunk_range_core.sv =====
module tb_viewport_chunk_range_core;
	timeunit 1ns;
	timeprecision 1ps;
	import vcr_pkg::*;

	typedef enum int {
		REG_CELL_SIZE,
		REG_MAP_WIDTH,
		REG_MAP_HEIGHT,
		REG_CHUNK_SIZE,
		REG_CHUNK_COUNT_X,
		REG_CHUNK_COUNT_Y
	} geom_reg_e;

	localparam longint ONE_CELL  = 65536;
	localparam longint MAP_SPAN  = 256 * ONE_CELL;
	localparam longint CHUNK_SPAN = 16 * ONE_CELL;
	localparam longint POS_MAX   = 64'sh7FFF_FFFF_FFFF;
	localparam longint POS_MIN   = -64'sh8000_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        query_valid = 1'b0;
	logic        query_ready;
	query_t      query = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	longint unsigned geom [6];
	result_t expected_ranges [$];
	int mismatch_count = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 50;

	viewport_chunk_range_core dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic longint unsigned nonzero(longint unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic longint unsigned edge_to_chunk(longint e, longint unsigned count);
		longint unsigned chunk;
		if (e <= 0) return 0;
		chunk = (unsigned'(e) / nonzero(geom[REG_CELL_SIZE])) / nonzero(geom[REG_CHUNK_SIZE]);
		if (chunk > count - 1) chunk = count - 1;
		return chunk;
	endfunction

	function automatic void axis_range(input longint lo, input longint hi,
			input longint map_max, input longint unsigned count,
			input longint unsigned margin,
			output logic [IDX_W-1:0] lo_idx, output logic [IDX_W-1:0] hi_idx);
		longint top;
		longint unsigned a;
		longint unsigned b;
		top = (hi < map_max) ? hi : map_max;
		if (top > 0) top -= 1;
		a = edge_to_chunk((lo > 0) ? lo : 0, count);
		b = edge_to_chunk(top, count);
		a = (a > margin) ? a - margin : 0;
		b = b + margin;
		if (b > count - 1) b = count - 1;
		lo_idx = a[IDX_W-1:0];
		hi_idx = b[IDX_W-1:0];
	endfunction

	function automatic result_t predict_range(query_t q);
		longint cx, cy, hw, hh, cs, map_x, map_y, widen;
		longint unsigned margin;
		logic [IDX_W-1:0] ax, bx, ay, by;
		result_t r;
		cx = {{(64-POS_W){q.center_x[POS_W-1]}}, q.center_x};
		cy = {{(64-POS_W){q.center_y[POS_W-1]}}, q.center_y};
		hw = {{(64-HALF_W){1'b0}}, q.half_width};
		hh = {{(64-HALF_W){1'b0}}, q.half_height};
		margin = q.margin_chunks;
		cs = longint'(geom[REG_CELL_SIZE]);
		map_x = longint'(geom[REG_MAP_WIDTH]) * cs;
		map_y = longint'(geom[REG_MAP_HEIGHT]) * cs;
		widen = longint'(margin) * longint'(geom[REG_CHUNK_SIZE]) * cs;
		r = '0;
		if (cx + hw + widen <= 0 || cy + hh + widen <= 0 ||
				cx - hw - widen >= map_x || cy - hh - widen >= map_y)
			return r;
		axis_range(cx - hw, cx + hw, map_x, nonzero(geom[REG_CHUNK_COUNT_X]), margin, ax, bx);
		axis_range(cy - hh, cy + hh, map_y, nonzero(geom[REG_CHUNK_COUNT_Y]), margin, ay, by);
		r.intersects = 1'b1;
		r.min_chunk_x = ax;
		r.min_chunk_y = ay;
		r.max_chunk_x = bx;
		r.max_chunk_y = by;
		return r;
	endfunction

	function automatic query_t mk_query(longint cx, longint cy, longint hw, longint hh,
			int unsigned margin);
		query_t q;
		q.center_x = POS_W'(cx);
		q.center_y = POS_W'(cy);
		q.half_width = HALF_W'(hw);
		q.half_height = HALF_W'(hh);
		q.margin_chunks = IDX_W'(margin);
		return q;
	endfunction

	function automatic longint unsigned rand_below(longint unsigned n);
		longint unsigned r;
		r = {$urandom, $urandom};
		return r % n;
	endfunction

	function automatic query_t rand_query();
		query_t q;
		longint ext_x, ext_y;
		longint unsigned r;
		if ($urandom_range(99) < 15) begin
			r = {$urandom, $urandom};
			q.center_x = POS_W'(r);
			r = {$urandom, $urandom};
			q.center_y = POS_W'(r);
			r = {$urandom, $urandom};
			q.half_width = HALF_W'(r);
			r = {$urandom, $urandom};
			q.half_height = HALF_W'(r);
			q.margin_chunks = IDX_W'($urandom_range(65535));
			return q;
		end
		ext_x = longint'(geom[REG_MAP_WIDTH] * geom[REG_CELL_SIZE]);
		ext_y = longint'(geom[REG_MAP_HEIGHT] * geom[REG_CELL_SIZE]);
		if (ext_x < 4) ext_x = 4;
		if (ext_y < 4) ext_y = 4;
		q.center_x = POS_W'(longint'(rand_below(ext_x * 3 / 2 + 2)) - ext_x / 4);
		q.center_y = POS_W'(longint'(rand_below(ext_y * 3 / 2 + 2)) - ext_y / 4);
		q.half_width = HALF_W'(1 + rand_below(ext_x / 3 + 1));
		q.half_height = HALF_W'(1 + rand_below(ext_y / 3 + 1));
		q.margin_chunks = IDX_W'(($urandom_range(9) < 9) ? $urandom_range(2) :
			$urandom_range(65535));
		return q;
	endfunction

	task automatic check_field(string name, longint unsigned exp, longint unsigned act);
		if (exp != act) begin
			$error("%s expected %0d got %0d", name, exp, act);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t exp;
		if (arst_n && result_valid && result_ready) begin
			if (expected_ranges.size() == 0) begin
				$error("result beat with no query outstanding");
				mismatch_count++;
			end else begin
				exp = expected_ranges.pop_front();
				check_field("intersects", exp.intersects, result.intersects);
				check_field("min_chunk_x", exp.min_chunk_x, result.min_chunk_x);
				check_field("min_chunk_y", exp.min_chunk_y, result.min_chunk_y);
				check_field("max_chunk_x", exp.max_chunk_x, result.max_chunk_x);
				check_field("max_chunk_y", exp.max_chunk_y, result.max_chunk_y);
			end
		end
	end

	task automatic send_query(input query_t q);
		result_t exp;
		exp = predict_range(q);
		if ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		query <= q;
		query_valid <= 1'b1;
		do @(posedge clk); while (!query_ready);
		expected_ranges.insert(expected_ranges.size(), exp);
	endtask

	task automatic wait_drained();
		query_valid <= 1'b0;
		do @(posedge clk); while (expected_ranges.size() != 0);
	endtask

	task automatic write_geometry(geom_reg_e idx, longint unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		geom[idx] = value & ((idx == REG_CELL_SIZE) ? 64'hF_FFFF : 64'hFFFF);
		@(posedge clk);
	endtask

	task automatic set_geometry(longint unsigned cs, longint unsigned w, longint unsigned h,
			longint unsigned chunk, longint unsigned cnt_x, longint unsigned cnt_y);
		write_geometry(REG_CELL_SIZE, cs);
		write_geometry(REG_MAP_WIDTH, w);
		write_geometry(REG_MAP_HEIGHT, h);
		write_geometry(REG_CHUNK_SIZE, chunk);
		write_geometry(REG_CHUNK_COUNT_X, cnt_x);
		write_geometry(REG_CHUNK_COUNT_Y, cnt_y);
	endtask

	task automatic test_reset_geometry();
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, MAP_SPAN, MAP_SPAN, 0));
		send_query(mk_query(-100 * ONE_CELL, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN / 2, -100 * ONE_CELL, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(-2 * ONE_CELL, -2 * ONE_CELL, ONE_CELL, ONE_CELL, 1));
		send_query(mk_query(MAP_SPAN + 2 * ONE_CELL, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN + 2 * ONE_CELL, ONE_CELL, ONE_CELL, 1));
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, 0, 0, 0));
		send_query(mk_query(CHUNK_SPAN / 2, CHUNK_SPAN / 2, CHUNK_SPAN / 2, CHUNK_SPAN / 2, 0));
		send_query(mk_query(-ONE_CELL, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN + ONE_CELL, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN - ONE_CELL, MAP_SPAN - ONE_CELL, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 65535));
		send_query(mk_query(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 65535));
		send_query(mk_query(POS_MIN, POS_MAX, POS_MAX, POS_MAX, 0));
		send_query(mk_query(-1, -1, POS_MAX, POS_MAX, 0));
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 65535));
		send_query(mk_query(MAP_SPAN / 3, MAP_SPAN / 5, 3 * ONE_CELL, ONE_CELL, 3));
		send_query(mk_query(0, 0, 1, 1, 0));
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, 1, 1, 0));
		wait_drained();
	endtask

	task automatic test_zero_registers();
		set_geometry(0, 0, 0, 0, 0, 0);
		send_query(mk_query(MAP_SPAN / 2, MAP_SPAN / 2, MAP_SPAN, MAP_SPAN, 0));
		send_query(mk_query(0, 0, POS_MAX, POS_MAX, 65535));
		send_query(rand_query());
		wait_drained();
		set_geometry(1, 100, 100, 0, 0, 0);
		send_query(mk_query(50, 50, 10, 10, 0));
		send_query(mk_query(50, 50, 10, 10, 2));
		send_query(mk_query(-5, 99, 3, 3, 0));
		send_query(mk_query(0, 0, POS_MAX, POS_MAX, 0));
		wait_drained();
		set_geometry(ONE_CELL, 0, 0, 16, 16, 16);
		send_query(mk_query(0, 0, POS_MAX, POS_MAX, 65535));
		send_query(mk_query(ONE_CELL, ONE_CELL, ONE_CELL, ONE_CELL, 1));
		wait_drained();
	endtask

	task automatic test_extreme_geometry();
		longint ext;
		set_geometry(20'hF_FFFF, 65535, 65535, 1, 65535, 65535);
		ext = 65535 * longint'(20'hF_FFFF);
		send_query(mk_query(0, 0, POS_MAX, POS_MAX, 0));
		send_query(mk_query(ext / 2, ext / 2, 1, 1, 65535));
		send_query(mk_query(ext - 1, ext - 1, 1, 1, 0));
		repeat (15) send_query(rand_query());
		wait_drained();
		set_geometry(1, 1, 1, 65535, 1, 1);
		send_query(mk_query(0, 0, 1, 1, 0));
		send_query(mk_query(1, 1, 1, 1, 65535));
		repeat (10) send_query(rand_query());
		wait_drained();
		set_geometry(ONE_CELL, 256, 256, 16, 4, 4);
		send_query(mk_query(MAP_SPAN * 3 / 4, MAP_SPAN * 3 / 4, ONE_CELL, ONE_CELL, 0));
		send_query(mk_query(MAP_SPAN * 3 / 4, MAP_SPAN / 2, ONE_CELL, ONE_CELL, 1));
		repeat (10) send_query(rand_query());
		wait_drained();
	endtask

	task automatic test_random_geometry();
		longint unsigned cs, w, h, chunk;
		for (int k = 0; k < 6; k++) begin
			case (k / 2)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case ($urandom_range(2))
				0: cs = $urandom_range(20'hF_FFFF, 1);
				1: cs = $urandom_range(255, 1);
				default: cs = ONE_CELL;
			endcase
			w = ($urandom_range(7) == 0) ? $urandom_range(65535, 1) : $urandom_range(300, 1);
			h = ($urandom_range(7) == 0) ? $urandom_range(65535, 1) : $urandom_range(300, 1);
			chunk = $urandom_range(32, 1);
			if ($urandom_range(3) == 0)
				set_geometry(cs, w, h, chunk, $urandom_range(16, 1), $urandom_range(16, 1));
			else
				set_geometry(cs, w, h, chunk, (w + chunk - 1) / chunk, (h + chunk - 1) / chunk);
			repeat (57) send_query(rand_query());
			// hold off until the pipe empties, then refill
			wait_drained();
			repeat (58) send_query(rand_query());
			wait_drained();
		end
	endtask

	initial begin
		geom = '{65536, 256, 256, 16, 16, 16};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_zero_registers();
		test_extreme_geometry();
		test_random_geometry();
		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== viewport_chunk_range_core.f =====
sv/vcr_pkg.sv
sv/vcr_div_pipe.sv
sv/viewport_chunk_range_core.sv
dv/tb_viewport_chunk_range_core.sv
